// ===== rtl/core/bmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants for the BGP message classifier: header offsets,
// message type codes, result classes and the records passed between stages.
// ----------------------------------------------------------------------------
package bmc_pkg;

  // header byte offsets (big-endian fields)
  localparam logic [15:0] OFF_LEN_HI    = 16'd16;
  localparam logic [15:0] OFF_LEN_LO    = 16'd17;
  localparam logic [15:0] OFF_TYPE      = 16'd18;
  localparam logic [15:0] OFF_WDR_HI    = 16'd19;
  localparam logic [15:0] OFF_WDR_LO    = 16'd20;
  localparam logic [16:0] OFF_ATTR_BASE = 17'd21;
  localparam logic [16:0] SHORT_MAX_LEN = 17'd18;
  localparam logic [16:0] UPD_MIN_LEN   = 17'd23;
  localparam logic [15:0] OFFSET_MAX    = 16'hFFFF;

  // message type codes
  localparam logic [7:0] TYPE_OPEN      = 8'd1;
  localparam logic [7:0] TYPE_UPDATE    = 8'd2;
  localparam logic [7:0] TYPE_NOTIF     = 8'd3;
  localparam logic [7:0] TYPE_KEEPALIVE = 8'd4;

  localparam int NUM_CLASSES = 12;
  localparam int CLASS_W     = 4;
  localparam int COUNT_W     = 32;

  typedef enum logic [CLASS_W-1:0] {
    CLS_OPEN       = 4'd0,
    CLS_EOR        = 4'd1,
    CLS_WITHDRAW   = 4'd2,
    CLS_MPBGP      = 4'd3,
    CLS_UPDATE     = 4'd4,
    CLS_MIXED      = 4'd5,
    CLS_NOTIF      = 4'd6,
    CLS_KEEPALIVE  = 4'd7,
    CLS_BADTYPE    = 4'd8,
    CLS_LENMISMATCH = 4'd9,
    CLS_SHORT      = 4'd10,
    CLS_BADUPDATE  = 4'd11
  } msg_class_t;

  // header fields of one finished message
  typedef struct packed {
    logic [16:0] len;
    logic [15:0] decl_len;
    logic [7:0]  mtype;
    logic [15:0] wdr_len;
    logic [15:0] attr_len;
  } msg_sum_t;

  // classification of one message
  typedef struct packed {
    msg_class_t cls;
    logic       plain_upd;
    logic       no_nlri;
  } cls_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/bgp_message_classifier_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgp_message_classifier_unit
// Byte-stream BGP-4 message header parser and classifier with counters.
// ----------------------------------------------------------------------------
// Takes one message byte per beat, marker first, with tlast on the final
// byte, and emits one result beat per message carrying its class, the update
// flags, the running message count and the running count for that class.
// A byte can be taken every cycle while the result side keeps up; after the
// last byte of a message is accepted, its result beat passes through the
// summary register, then the class register, then the counter and output
// register. With the output stalled, up to three finished messages are held
// before the input stalls. Bytes other than the last produce no result beat.
module bgp_message_classifier_unit
  import bmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata    // [3:0] msg_class, [4] plain_upd, [5] no_nlri,
                                      // [37:6] msg_number, [69:38] class_total, [71:70] 0
);

  logic     sum_valid;
  logic     sum_ready;
  msg_sum_t sum;
  logic     res_valid;
  logic     res_ready;
  cls_res_t res;
  cls_res_t out_res;
  logic [COUNT_W-1:0] out_number;
  logic [COUNT_W-1:0] out_total;

  // header capture
  bmc_capture u_capture (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  // classification
  bmc_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // counters and output register
  bmc_count u_count (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res),
    .out_number (out_number),
    .out_total  (out_total)
  );

  // result beat packing
  assign m_tdata = {2'b00, out_total, out_number, out_res.no_nlri, out_res.plain_upd,
                    out_res.cls};

  // update flag only on a plain update
  a_update_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> (m_tdata[3:0] == CLS_UPDATE))
    else $error("update flag set on a non-update class");

  // no-nlri flag only on a mixed update
  a_no_nlri_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[5]) |-> (m_tdata[3:0] == CLS_MIXED))
    else $error("no_nlri set on a non-mixed class");

  // class code in range
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] <= CLS_BADUPDATE))
    else $error("class code out of range");

  // an empty output register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");

endmodule

`default_nettype wire

// ===== rtl/core/bmc_capture.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_capture
// Tracks the byte offset, captures the header fields as bytes go by and
// registers a summary of the message on its last byte.
// ----------------------------------------------------------------------------
module bmc_capture
  import bmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic     in_last,
  output logic          sum_valid,
  input  wire logic     sum_ready,
  output msg_sum_t      sum
);

  logic [15:0] byte_offset;
  logic [15:0] decl_len;
  logic [7:0]  mtype;
  logic [15:0] wdr_len;
  logic [15:0] attr_len;

  logic [15:0] decl_len_next;
  logic [7:0]  mtype_next;
  logic [15:0] wdr_len_next;
  logic [15:0] attr_len_next;
  logic [16:0] off_ext;
  logic [16:0] attr_pos;
  logic        accept;

  assign in_ready = !sum_valid || sum_ready;
  assign accept   = in_valid && in_ready;
  assign off_ext  = {1'b0, byte_offset};
  assign attr_pos = OFF_ATTR_BASE + {1'b0, wdr_len};

  // field capture for the current byte
  always_comb begin
    decl_len_next = decl_len;
    mtype_next    = mtype;
    wdr_len_next  = wdr_len;
    attr_len_next = attr_len;
    if (byte_offset == OFF_LEN_HI) begin
      decl_len_next = {in_byte, decl_len[7:0]};
    end else if (byte_offset == OFF_LEN_LO) begin
      decl_len_next = {decl_len[15:8], in_byte};
    end else if (byte_offset == OFF_TYPE) begin
      mtype_next = in_byte;
    end else if (mtype == TYPE_UPDATE) begin
      if (byte_offset == OFF_WDR_HI) begin
        wdr_len_next = {in_byte, wdr_len[7:0]};
      end else if (byte_offset == OFF_WDR_LO) begin
        wdr_len_next = {wdr_len[15:8], in_byte};
      end else if (off_ext == attr_pos) begin
        attr_len_next = {in_byte, attr_len[7:0]};
      end else if (off_ext == attr_pos + 17'd1) begin
        attr_len_next = {attr_len[15:8], in_byte};
      end
    end
  end

  // per-message state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      decl_len    <= '0;
      mtype       <= '0;
      wdr_len     <= '0;
      attr_len    <= '0;
    end else if (accept) begin
      if (in_last) begin
        byte_offset <= '0;
        decl_len    <= '0;
        mtype       <= '0;
        wdr_len     <= '0;
        attr_len    <= '0;
      end else begin
        if (byte_offset != OFFSET_MAX) begin
          byte_offset <= byte_offset + 16'd1;
        end
        decl_len <= decl_len_next;
        mtype    <= mtype_next;
        wdr_len  <= wdr_len_next;
        attr_len <= attr_len_next;
      end
    end
  end

  // summary register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (accept && in_last) begin
      sum_valid <= 1'b1;
    end else if (sum_ready) begin
      sum_valid <= 1'b0;
    end
  end

  // summary payload
  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      sum.len      <= off_ext + 17'd1;
      sum.decl_len <= decl_len_next;
      sum.mtype    <= mtype_next;
      sum.wdr_len  <= wdr_len_next;
      sum.attr_len <= attr_len_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bmc_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_classify
// Checks the summary of a finished message and registers its class and the
// update flags.
// ----------------------------------------------------------------------------
module bmc_classify
  import bmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     sum_valid,
  output logic          sum_ready,
  input  wire msg_sum_t sum,
  output logic          res_valid,
  input  wire logic     res_ready,
  output cls_res_t      res
);

  logic [17:0] need;
  logic [17:0] len_ext;
  logic        too_short_upd;
  logic        nlri_zero;
  cls_res_t    res_next;

  assign sum_ready = !res_valid || res_ready;
  assign len_ext   = {1'b0, sum.len};
  assign need      = {1'b0, UPD_MIN_LEN} + {2'b0, sum.wdr_len} + {2'b0, sum.attr_len};
  assign too_short_upd = len_ext < need;
  // nlri length is zero exactly when the message ends at the attributes
  assign nlri_zero = len_ext == need;

  // class decision
  always_comb begin
    res_next.cls       = CLS_BADTYPE;
    res_next.plain_upd = 1'b0;
    res_next.no_nlri   = 1'b0;
    if (sum.len <= SHORT_MAX_LEN) begin
      res_next.cls = CLS_SHORT;
    end else if (sum.len != {1'b0, sum.decl_len}) begin
      res_next.cls = CLS_LENMISMATCH;
    end else begin
      unique case (sum.mtype)
        TYPE_OPEN:      res_next.cls = CLS_OPEN;
        TYPE_NOTIF:     res_next.cls = CLS_NOTIF;
        TYPE_KEEPALIVE: res_next.cls = CLS_KEEPALIVE;
        TYPE_UPDATE: begin
          if (too_short_upd) begin
            res_next.cls = CLS_BADUPDATE;
          end else if (sum.len == UPD_MIN_LEN) begin
            res_next.cls = CLS_EOR;
          end else if (sum.attr_len == 16'd0) begin
            res_next.cls = nlri_zero ? CLS_WITHDRAW : CLS_BADUPDATE;
          end else if (sum.wdr_len == 16'd0) begin
            if (nlri_zero) begin
              res_next.cls = CLS_MPBGP;
            end else begin
              res_next.cls       = CLS_UPDATE;
              res_next.plain_upd = 1'b1;
            end
          end else begin
            res_next.cls     = CLS_MIXED;
            res_next.no_nlri = nlri_zero;
          end
        end
        default:        res_next.cls = CLS_BADTYPE;
      endcase
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (sum_valid && sum_ready) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bmc_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmc_count
// Keeps the wrapping message and per-class counters and holds the output
// register for the result beat.
// ----------------------------------------------------------------------------
module bmc_count
  import bmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     res_valid,
  output logic          res_ready,
  input  wire cls_res_t res,
  output logic          out_valid,
  input  wire logic     out_ready,
  output cls_res_t      out_res,
  output logic [COUNT_W-1:0] out_number,
  output logic [COUNT_W-1:0] out_total
);

  logic [COUNT_W-1:0] message_total;
  logic [COUNT_W-1:0] class_counters [NUM_CLASSES];
  logic [COUNT_W-1:0] total_next;
  logic [COUNT_W-1:0] class_next;
  logic [CLASS_W-1:0] cls_idx;
  logic               take;

  assign res_ready  = !out_valid || out_ready;
  assign take       = res_valid && res_ready;
  assign cls_idx    = res.cls;
  assign total_next = message_total + 32'd1;
  assign class_next = class_counters[cls_idx] + 32'd1;

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      message_total <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        class_counters[i] <= '0;
      end
    end else if (take) begin
      message_total           <= total_next;
      class_counters[cls_idx] <= class_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_res    <= res;
      out_number <= total_next;
      out_total  <= class_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/bgp_message_classifier_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_message_classifier_unit_checker
// Watches both streams of the classifier. It keeps its own copy of the header
// capture state and the class counters, works out the class beat for every
// message that ends on the input, and compares each output beat, field by
// field, with the oldest message still waiting for its result.
// ----------------------------------------------------------------------------
module bgp_message_classifier_unit_checker
  import bmc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [71:0] m_tdata,   // [3:0] msg_class, [4] plain_upd, [5] no_nlri,
                                      // [37:6] msg_number, [69:38] class_total
  output int               mismatches,
  output int               awaiting
);

  typedef struct {
    msg_class_t  cls;
    logic        plain_upd;
    logic        no_nlri;
    logic [31:0] msg_number;
    logic [31:0] class_total;
  } class_beat_t;

  // header capture state of the message in flight
  logic [15:0] offset;
  logic [15:0] decl_len;
  logic [7:0]  mtype;
  logic [15:0] wdr_len;
  logic [15:0] attr_len;

  // wrapping counters
  logic [31:0] msgs_seen;
  logic [31:0] per_class [NUM_CLASSES];

  class_beat_t class_beats_due [$];

  initial mismatches = 0;

  task automatic note_mismatch(input string msg);
    if (mismatches < 100) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic clear_header();
    offset   = '0;
    decl_len = '0;
    mtype    = '0;
    wdr_len  = '0;
    attr_len = '0;
  endtask

  // classes of a type 2 message whose length agrees with the header
  function automatic msg_class_t classify_update(input logic [16:0] len, output logic upd,
                                                 output logic nonlri);
    logic [17:0] need;
    logic [17:0] nlri;
    upd    = 1'b0;
    nonlri = 1'b0;
    need   = 18'd23 + {2'b0, wdr_len} + {2'b0, attr_len};
    if ({1'b0, len} < need) return CLS_BADUPDATE;
    nlri = {1'b0, len} - need;
    if (len == UPD_MIN_LEN) return CLS_EOR;
    if (attr_len == 16'd0) begin
      if (nlri == 18'd0) return CLS_WITHDRAW;
      return CLS_BADUPDATE;
    end
    if (wdr_len == 16'd0) begin
      if (nlri == 18'd0) return CLS_MPBGP;
      upd = 1'b1;
      return CLS_UPDATE;
    end
    nonlri = (nlri == 18'd0);
    return CLS_MIXED;
  endfunction

  // capture one byte; on the last one, classify and queue the class beat
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [16:0] ap;
    logic [16:0] len;
    msg_class_t  cls;
    logic        upd;
    logic        nonlri;
    class_beat_t beat;
    ap = OFF_ATTR_BASE + {1'b0, wdr_len};
    if (offset == OFF_LEN_HI) decl_len[15:8] = b;
    else if (offset == OFF_LEN_LO) decl_len[7:0] = b;
    else if (offset == OFF_TYPE) mtype = b;
    else if (mtype == TYPE_UPDATE) begin
      if (offset == OFF_WDR_HI) wdr_len[15:8] = b;
      else if (offset == OFF_WDR_LO) wdr_len[7:0] = b;
      else if ({1'b0, offset} == ap) attr_len[15:8] = b;
      else if ({1'b0, offset} == ap + 17'd1) attr_len[7:0] = b;
    end
    if (!last) begin
      if (offset != OFFSET_MAX) offset = offset + 16'd1;
    end else begin
      len    = {1'b0, offset} + 17'd1;
      upd    = 1'b0;
      nonlri = 1'b0;
      if (len <= SHORT_MAX_LEN) cls = CLS_SHORT;
      else if (len != {1'b0, decl_len}) cls = CLS_LENMISMATCH;
      else if (mtype == TYPE_OPEN) cls = CLS_OPEN;
      else if (mtype == TYPE_UPDATE) cls = classify_update(len, upd, nonlri);
      else if (mtype == TYPE_NOTIF) cls = CLS_NOTIF;
      else if (mtype == TYPE_KEEPALIVE) cls = CLS_KEEPALIVE;
      else cls = CLS_BADTYPE;
      msgs_seen      = msgs_seen + 32'd1;
      per_class[cls] = per_class[cls] + 32'd1;
      beat.cls         = cls;
      beat.plain_upd   = upd;
      beat.no_nlri     = nonlri;
      beat.msg_number  = msgs_seen;
      beat.class_total = per_class[cls];
      class_beats_due.push_back(beat);
      clear_header();
    end
  endtask

  // compare one output beat with the oldest message waiting
  task automatic check_class_beat(input logic [71:0] got);
    class_beat_t want;
    if (class_beats_due.size() == 0) begin
      note_mismatch($sformatf("result beat %h with no message waiting", got));
      return;
    end
    want = class_beats_due.pop_front();
    if (got[3:0] !== want.cls)
      note_mismatch($sformatf("msg %0d msg_class %0d, want %0d", want.msg_number, got[3:0],
                              want.cls));
    if (got[4] !== want.plain_upd)
      note_mismatch($sformatf("msg %0d plain_upd %b, want %b", want.msg_number, got[4],
                              want.plain_upd));
    if (got[5] !== want.no_nlri)
      note_mismatch($sformatf("msg %0d no_nlri %b, want %b", want.msg_number, got[5],
                              want.no_nlri));
    if (got[37:6] !== want.msg_number)
      note_mismatch($sformatf("msg_number %0d, want %0d", got[37:6], want.msg_number));
    if (got[69:38] !== want.class_total)
      note_mismatch($sformatf("msg %0d class_total %0d, want %0d", want.msg_number,
                              got[69:38], want.class_total));
  endtask

  // sample both streams at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_header();
      msgs_seen = '0;
      for (int i = 0; i < NUM_CLASSES; i++) per_class[i] = '0;
      class_beats_due.delete();
    end else begin
      if (s_tvalid && s_tready) absorb_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) check_class_beat(m_tdata);
    end
    awaiting <= class_beats_due.size();
  end

endmodule

// ===== tb/bgp_message_classifier_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgp_message_classifier_unit_tb
// Feeds BGP messages byte by byte into the classifier: a directed set that
// hits every class and the short case, then random well-formed messages
// mixed with noise, with random gaps on both streams.
// The checker beside the block predicts and compares the class beats.
// ----------------------------------------------------------------------------
module bgp_message_classifier_unit_tb;
  import bmc_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  wire  logic        s_tready;
  wire  logic        m_tvalid;
  wire  logic [71:0] m_tdata;

  int   mismatches;
  int   awaiting;
  logic steady = 1'b0;   // no gaps on either stream while set
  int   sent_bytes = 0;
  int   sent_msgs  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bgp_message_classifier_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  bgp_message_classifier_unit_checker classifier_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  // random stalls on the result side
  always @(posedge clk) m_tready <= steady || ($urandom_range(0, 99) >= 38);

  // hard stop
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // one input beat, after a random number of idle cycles
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // one message of len bytes with the given header fields, random filler
  task automatic send_message(input int len, input logic [15:0] decl, input logic [7:0] mtype,
                              input logic [15:0] wdr, input logic [15:0] attr,
                              input logic scramble);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i < 16) begin
        if (!scramble) b = 8'hFF;
      end else if (i == 16) b = decl[15:8];
      else if (i == 17) b = decl[7:0];
      else if (i == 18) b = mtype;
      else if (mtype == TYPE_UPDATE) begin
        if (i == 19) b = wdr[15:8];
        else if (i == 20) b = wdr[7:0];
        else if (i == 21 + int'(wdr)) b = attr[15:8];
        else if (i == 22 + int'(wdr)) b = attr[7:0];
      end
      send_byte(b, i == len - 1);
    end
    sent_bytes += len;
    sent_msgs++;
  endtask

  // consistent update with the given section lengths
  task automatic send_update(input int wdr, input int attr, input int nlri);
    int len;
    len = 23 + wdr + attr + nlri;
    send_message(len, 16'(len), TYPE_UPDATE, 16'(wdr), 16'(attr), 1'b0);
  endtask

  // mostly well-formed messages, the rest noise and broken headers
  task automatic send_random_message();
    int pick;
    int len;
    int wdr;
    int attr;
    int nlri;
    logic [15:0] decl;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_message(19, 16'd19, TYPE_KEEPALIVE, 16'd0, 16'd0, 1'b0);
    end else if (pick < 20) begin
      len = 29 + $urandom_range(0, 16);
      send_message(len, 16'(len), TYPE_OPEN, 16'd0, 16'd0, 1'b0);
    end else if (pick < 30) begin
      len = 21 + $urandom_range(0, 12);
      send_message(len, 16'(len), TYPE_NOTIF, 16'd0, 16'd0, 1'b0);
    end else if (pick < 75) begin
      wdr  = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      attr = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
      nlri = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      send_update(wdr, attr, nlri);
    end else begin
      len  = $urandom_range(1, 50);
      decl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(len);
      wdr  = $urandom_range(0, 1) ? int'(16'($urandom)) : $urandom_range(0, 20);
      send_message(len, decl, ($urandom_range(0, 1) ? TYPE_UPDATE : 8'($urandom)),
                   16'(wdr), 16'($urandom), 1'b1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: short, every class, bad headers
    send_message(1, 16'd0, 8'd0, 16'd0, 16'd0, 1'b0);
    send_message(18, 16'd18, TYPE_KEEPALIVE, 16'd0, 16'd0, 1'b0);
    send_message(19, 16'd19, TYPE_KEEPALIVE, 16'd0, 16'd0, 1'b0);
    send_message(29, 16'd29, TYPE_OPEN, 16'd0, 16'd0, 1'b0);
    send_message(21, 16'd21, TYPE_NOTIF, 16'd0, 16'd0, 1'b0);
    send_update(0, 0, 0);
    send_update(4, 0, 0);
    send_update(0, 5, 0);
    send_update(0, 5, 4);
    send_update(3, 5, 0);
    send_update(3, 5, 4);
    send_message(19, 16'd19, 8'd0, 16'd0, 16'd0, 1'b0);
    send_message(19, 16'd19, 8'hFF, 16'd0, 16'd0, 1'b0);
    send_message(25, 16'd24, TYPE_KEEPALIVE, 16'd0, 16'd0, 1'b0);
    send_message(23, 16'd23, TYPE_UPDATE, 16'hFFFF, 16'd0, 1'b0);
    send_message(27, 16'd27, TYPE_UPDATE, 16'd0, 16'd0, 1'b0);

    // random part, with one stretch free of gaps
    while (sent_bytes < 1100) begin
      steady <= (sent_msgs >= 22 && sent_msgs < 32);
      send_random_message();
    end
    steady   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    // drain, then allow for the result pipeline
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && awaiting == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bmc_pkg.sv
rtl/core/bmc_capture.sv
rtl/core/bmc_classify.sv
rtl/core/bmc_count.sv
rtl/core/bgp_message_classifier_unit.sv
tb/bgp_message_classifier_unit_checker.sv
tb/bgp_message_classifier_unit_tb.sv
